// ----- rtl/tea_cbc_block_cipher_macros.svh -----
// Assertion macros used by the checker file of the TEA CBC block.
`ifndef TEA_CBC_BLOCK_CIPHER_MACROS_SVH
`define TEA_CBC_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TCBC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TCBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tcbc_pkg.sv -----
// Package with constants, types and the round function of the TEA CBC block.
`default_nettype none
package tcbc_pkg;
	localparam int TCBC_ROUNDS = 32;
	localparam int TCBC_DW = 32;
	localparam logic [31:0] TCBC_DELTA = 32'h9E37_79B9;
	localparam logic [31:0] TCBC_IV_LOW = 32'h0123_4567;
	localparam logic [31:0] TCBC_IV_HIGH = 32'h89AB_CDEF;

	// input queue depth, a power of two
	localparam int TCBC_QDEPTH = 2;
	localparam int TCBC_QAW = $clog2(TCBC_QDEPTH);

	localparam int TCBC_CFG_IW = 3;
	localparam logic [TCBC_CFG_IW-1:0] CFG_KEY0 = 3'd0;
	localparam logic [TCBC_CFG_IW-1:0] CFG_KEY1 = 3'd1;
	localparam logic [TCBC_CFG_IW-1:0] CFG_KEY2 = 3'd2;
	localparam logic [TCBC_CFG_IW-1:0] CFG_KEY3 = 3'd3;
	localparam logic [TCBC_CFG_IW-1:0] CFG_MODE = 3'd4;

	typedef struct packed {
		logic [3:0][31:0] key;
		logic             decrypt;
	} tcbc_cfg_t;

	typedef struct packed {
		logic [31:0] low;
		logic [31:0] high;
		logic        decrypt;
	} tcbc_word_t;

	function automatic logic [31:0] tcbc_mix(input logic [31:0] w, input logic [31:0] sum,
			input logic [31:0] ka, input logic [31:0] kb);
		return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
	endfunction
endpackage
`default_nettype wire

// ----- rtl/tcbc_ifs.sv -----
// Valid/ready channel interfaces for input blocks and result blocks.
`default_nettype none
interface tcbc_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] block_low;
	logic [31:0] block_high;
	modport source (output valid, block_low, block_high, input ready);
	modport sink (input valid, block_low, block_high, output ready);
	modport mon (input valid, ready, block_low, block_high);
endinterface

interface tcbc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_low;
	logic [31:0] out_high;
	modport source (output valid, out_low, out_high, input ready);
	modport sink (input valid, out_low, out_high, output ready);
	modport mon (input valid, ready, out_low, out_high);
endinterface
`default_nettype wire

// ----- rtl/tcbc_front.sv -----
// Front end: accepts input words, tags them with the mode and queues them.
`default_nettype none
module tcbc_front
	import tcbc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	tcbc_in_if.sink         blk,
	input  wire logic       decrypt,
	output tcbc_word_t      q_word,
	output logic            q_valid,
	input  wire logic       q_ready
);
	tcbc_word_t mem_q [TCBC_QDEPTH];
	logic [TCBC_QAW-1:0] wr_ptr_q;
	logic [TCBC_QAW-1:0] rd_ptr_q;
	logic [TCBC_QAW:0]   cnt_q;
	logic push;
	logic pop;

	assign blk.ready = (cnt_q != (TCBC_QAW+1)'(TCBC_QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_word = mem_q[rd_ptr_q];
	assign push = blk.valid && blk.ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{low: blk.block_low, high: blk.block_high, decrypt: decrypt};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/tcbc_engine.sv -----
// Back end: iterative TEA rounds, CBC chaining and the result register.
`default_nettype none
module tcbc_engine
	import tcbc_pkg::*;
#(
	parameter int ROUNDS = TCBC_ROUNDS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire tcbc_cfg_t  cfg,
	input  wire logic       iv_load,
	input  wire tcbc_word_t q_word,
	input  wire logic       q_valid,
	output logic            q_ready,
	tcbc_out_if.source      res
);
	localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
	localparam logic [RW-1:0] LAST = RW'(ROUNDS - 1);
	localparam logic [31:0] SUM_DEC = 32'(64'(TCBC_DELTA) * 64'(ROUNDS));

	logic          busy_q;
	logic          dec_q;
	logic [RW-1:0] rnd_q;
	logic [31:0]   a_q, b_q, sum_q;
	logic [31:0]   ct_low_q, ct_high_q;
	logic [31:0]   chain_low_q, chain_high_q;
	logic          res_valid_q;
	logic [31:0]   res_low_q, res_high_q;

	logic [31:0] na, nb;
	logic [31:0] chain_low_nxt, chain_high_nxt;
	logic last, finish, advance, start;

	always_comb begin
		if (dec_q) begin
			nb = b_q - tcbc_mix(a_q, sum_q, cfg.key[2], cfg.key[3]);
			na = a_q - tcbc_mix(nb, sum_q, cfg.key[0], cfg.key[1]);
		end else begin
			na = a_q + tcbc_mix(b_q, sum_q, cfg.key[0], cfg.key[1]);
			nb = b_q + tcbc_mix(na, sum_q, cfg.key[2], cfg.key[3]);
		end
	end

	assign last = busy_q && (rnd_q == LAST);
	assign finish = last && (!res_valid_q || res.ready);
	assign advance = busy_q && !last;
	assign q_ready = !busy_q || finish;
	assign start = q_valid && q_ready;

	always_comb begin
		priority if (iv_load) begin
			chain_low_nxt = TCBC_IV_LOW;
			chain_high_nxt = TCBC_IV_HIGH;
		end else if (finish && dec_q) begin
			chain_low_nxt = ct_low_q;
			chain_high_nxt = ct_high_q;
		end else if (finish) begin
			chain_low_nxt = na;
			chain_high_nxt = nb;
		end else begin
			chain_low_nxt = chain_low_q;
			chain_high_nxt = chain_high_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q <= '0;
			res_valid_q <= 1'b0;
			chain_low_q <= TCBC_IV_LOW;
			chain_high_q <= TCBC_IV_HIGH;
		end else begin
			chain_low_q <= chain_low_nxt;
			chain_high_q <= chain_high_nxt;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q <= '0;
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dec_q <= q_word.decrypt;
			ct_low_q <= q_word.low;
			ct_high_q <= q_word.high;
			if (q_word.decrypt) begin
				a_q <= q_word.low;
				b_q <= q_word.high;
				sum_q <= SUM_DEC;
			end else begin
				a_q <= q_word.low ^ chain_low_nxt;
				b_q <= q_word.high ^ chain_high_nxt;
				sum_q <= TCBC_DELTA;
			end
		end else if (advance) begin
			a_q <= na;
			b_q <= nb;
			sum_q <= dec_q ? (sum_q - TCBC_DELTA) : (sum_q + TCBC_DELTA);
		end
		if (finish) begin
			res_low_q <= dec_q ? (na ^ chain_low_q) : na;
			res_high_q <= dec_q ? (nb ^ chain_high_q) : nb;
		end
	end

	assign res.valid = res_valid_q;
	assign res.out_low = res_low_q;
	assign res.out_high = res_high_q;
endmodule
`default_nettype wire

// ----- rtl/tea_cbc_block_cipher.sv -----
// Top level of the TEA block cipher in CBC mode.
// Each 64-bit block runs ROUNDS rounds in the round engine (32 by default),
// one full TEA round per cycle on a single shared round unit, but the last
// round waits until the result register is free; the next block enters the
// engine in the cycle its predecessor finishes. A two-word input queue and a
// result register decouple both channels. Writes to any key or mode
// register reload the IV 0x01234567/0x89ABCDEF; configure only while no
// block is in flight.
`default_nettype none
module tea_cbc_block_cipher
	import tcbc_pkg::*;
#(
	parameter int ROUNDS = TCBC_ROUNDS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	tcbc_in_if.sink                     blk,
	tcbc_out_if.source                  res,
	input  wire logic                   cfg_we,
	input  wire logic [TCBC_CFG_IW-1:0] cfg_index,
	input  wire logic [TCBC_DW-1:0]     cfg_wdata
);
	tcbc_cfg_t  cfg_q;
	tcbc_word_t q_word;
	logic       q_valid;
	logic       q_ready;
	logic       iv_load;

	assign iv_load = cfg_we && (cfg_index <= CFG_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY0: cfg_q.key[0] <= cfg_wdata;
				CFG_KEY1: cfg_q.key[1] <= cfg_wdata;
				CFG_KEY2: cfg_q.key[2] <= cfg_wdata;
				CFG_KEY3: cfg_q.key[3] <= cfg_wdata;
				CFG_MODE: cfg_q.decrypt <= cfg_wdata[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	tcbc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.blk     (blk),
		.decrypt (cfg_q.decrypt),
		.q_word  (q_word),
		.q_valid (q_valid),
		.q_ready (q_ready)
	);

	tcbc_engine #(
		.ROUNDS (ROUNDS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.iv_load (iv_load),
		.q_word  (q_word),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.res     (res)
	);
endmodule
`default_nettype wire

// ----- rtl/tcbc_checker.sv -----
// Port-level assertions for the TEA CBC block and their bind.
`default_nettype none
`include "tea_cbc_block_cipher_macros.svh"
module tcbc_checker
	import tcbc_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               blk_valid,
	input wire logic               blk_ready,
	input wire logic               res_valid,
	input wire logic               res_ready,
	input wire logic [TCBC_DW-1:0] res_out_low,
	input wire logic [TCBC_DW-1:0] res_out_high
);
	localparam int PW = $clog2(TCBC_QDEPTH + 3);
	localparam logic [PW-1:0] PEND_MAX = PW'(TCBC_QDEPTH + 2);

	logic [PW-1:0] pend_q;
	logic in_acc;
	logic out_acc;

	assign in_acc = blk_valid && blk_ready;
	assign out_acc = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + PW'(in_acc) - PW'(out_acc);
		end
	end

	`TCBC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_out_low) && $stable(res_out_high), "stalled result word changed or dropped")
	`TCBC_ASSERT_NOW(a_res_has_src, res_valid, pend_q != '0, "result word without an accepted input word")
	`TCBC_ASSERT_NOW(a_pend_bound, 1'b1, pend_q <= PEND_MAX, "more words in flight than the block can hold")
	`TCBC_ASSERT_NOW(a_full_stalls, pend_q == PEND_MAX, !blk_ready, "input taken with every stage full")
endmodule

bind tea_cbc_block_cipher tcbc_checker u_tcbc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.blk_valid    (blk.valid),
	.blk_ready    (blk.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_out_low  (res.out_low),
	.res_out_high (res.out_high)
);
`default_nettype wire

// ----- sim/tea_cbc_block_cipher_tb.sv -----
// Self-checking testbench for the TEA CBC block cipher: directed rows, random phases.
`default_nettype none
module tea_cbc_block_cipher_tb
	import tcbc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RESET_CYCLES = 11;
	localparam int LIMIT_CYCLES = 600000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 450;
	localparam int REPORT_MAX   = 10;
	localparam logic [TCBC_CFG_IW-1:0] CFG_SPARE_FIRST = CFG_MODE + 1'b1;
	localparam logic [TCBC_CFG_IW-1:0] CFG_SPARE_LAST  = '1;

	typedef enum logic {ROW_BLOCK, ROW_REG} row_kind_t;
	typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_RUNS} ready_pattern_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [TCBC_CFG_IW-1:0]  reg_idx;
		logic [31:0]             word_lo;
		logic [31:0]             word_hi;
		logic                    known;
		logic [31:0]             known_lo;
		logic [31:0]             known_hi;
	} stim_row_t;

	typedef struct packed {
		logic [31:0] word_lo;
		logic [31:0] word_hi;
		logic        known;
		logic [31:0] known_lo;
		logic [31:0] known_hi;
	} plain_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [TCBC_CFG_IW-1:0] cfg_index;
	logic [TCBC_DW-1:0] cfg_wdata;

	tcbc_in_if  blk_if();
	tcbc_out_if res_if();

	tea_cbc_block_cipher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk       (blk_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	logic [31:0] key_q [4];
	logic        mode_dec;
	logic [31:0] chain_lo;
	logic [31:0] chain_hi;

	plain_word_t blocks_to_send[$];
	logic [63:0] expected_blocks[$];
	stim_row_t   dir_rows[25];

	int cycles;
	int mismatches;
	int blocks_checked;
	int decrypt_checked;
	int settings_used;
	int gap_left;
	int burst_left;
	int hold_left;
	bit hold_request;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [31:0] tea_round_mix(input logic [31:0] w, input logic [31:0] s,
			input logic [31:0] ka, input logic [31:0] kb);
		return ((w << 4) + ka) ^ (w + s) ^ ((w >> 5) + kb);
	endfunction

	// returns {high, low} and advances the chain
	function automatic logic [63:0] cbc_predict(input logic [31:0] lo, input logic [31:0] hi);
		logic [31:0] v0;
		logic [31:0] v1;
		logic [31:0] s;
		v0 = lo;
		v1 = hi;
		s = '0;
		if (mode_dec) begin
			repeat (TCBC_ROUNDS) s += TCBC_DELTA;
			repeat (TCBC_ROUNDS) begin
				v1 -= tea_round_mix(v0, s, key_q[2], key_q[3]);
				v0 -= tea_round_mix(v1, s, key_q[0], key_q[1]);
				s -= TCBC_DELTA;
			end
			v0 ^= chain_lo;
			v1 ^= chain_hi;
			chain_lo = lo;
			chain_hi = hi;
		end else begin
			v0 ^= chain_lo;
			v1 ^= chain_hi;
			repeat (TCBC_ROUNDS) begin
				s += TCBC_DELTA;
				v0 += tea_round_mix(v1, s, key_q[0], key_q[1]);
				v1 += tea_round_mix(v0, s, key_q[2], key_q[3]);
			end
			chain_lo = v0;
			chain_hi = v1;
		end
		return {v1, v0};
	endfunction

	task automatic check_word(input string field, input logic [31:0] exp_w,
			input logic [31:0] act_w);
		if (act_w !== exp_w) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("mismatch on %s at cycle %0d: expected %h, got %h",
					field, cycles, exp_w, act_w);
		end
	endtask

	task automatic write_reg(input logic [TCBC_CFG_IW-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			CFG_KEY0: key_q[0] = val;
			CFG_KEY1: key_q[1] = val;
			CFG_KEY2: key_q[2] = val;
			CFG_KEY3: key_q[3] = val;
			CFG_MODE: mode_dec = val[0];
			default: ;
		endcase
		if (idx <= CFG_MODE) begin
			chain_lo = TCBC_IV_LOW;
			chain_hi = TCBC_IV_HIGH;
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (blocks_to_send.size() != 0 || expected_blocks.size() != 0)
			@(posedge clk);
		repeat (TCBC_ROUNDS + 8) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_blocks.size());
			$display("tea_cbc_block_cipher_tb: FAIL");
			$finish;
		end
	end

	// accept side: predict at the edge the word is taken
	always @(posedge clk) begin
		plain_word_t w;
		logic [63:0] pred;
		if (arst_n && blk_if.valid && blk_if.ready) begin
			w = blocks_to_send.pop_front();
			pred = cbc_predict(w.word_lo, w.word_hi);
			if (w.known)
				pred = {w.known_hi, w.known_lo};
			expected_blocks.push_back(pred);
			if (mode_dec)
				decrypt_checked++;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 12);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
			end
		end
	end

	// result side
	always @(posedge clk) begin
		logic [63:0] exp_b;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_blocks.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result at cycle %0d: %h %h",
						cycles, res_if.out_low, res_if.out_high);
			end else begin
				exp_b = expected_blocks.pop_front();
				check_word("out_low", exp_b[31:0], res_if.out_low);
				check_word("out_high", exp_b[63:32], res_if.out_high);
				blocks_checked++;
			end
		end
	end

	initial begin : sender
		blk_if.valid = 1'b0;
		blk_if.block_low = '0;
		blk_if.block_high = '0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (gap_left > 0) begin
				gap_left--;
				blk_if.valid <= 1'b0;
			end else if (blocks_to_send.size() != 0) begin
				blk_if.valid <= 1'b1;
				blk_if.block_low <= blocks_to_send[0].word_lo;
				blk_if.block_high <= blocks_to_send[0].word_hi;
			end else begin
				blk_if.valid <= 1'b0;
			end
		end
	end

	initial begin : receiver
		ready_pattern_t pattern;
		int pattern_left;
		int stall_left;
		pattern = RDY_ALWAYS;
		pattern_left = 0;
		stall_left = 0;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				if (pattern_left == 0) begin
					pattern = ready_pattern_t'($urandom_range(0, 2));
					pattern_left = $urandom_range(50, 300);
				end
				pattern_left--;
				case (pattern)
					RDY_ALWAYS: res_if.ready <= 1'b1;
					RDY_COIN: res_if.ready <= 1'($urandom_range(0, 1));
					default: begin
						if (stall_left > 0) begin
							stall_left--;
							res_if.ready <= 1'b0;
						end else begin
							res_if.ready <= 1'b1;
							if ($urandom_range(0, 7) == 0)
								stall_left = $urandom_range(5, 60);
						end
					end
				endcase
			end
		end
	end

	initial begin : main
		int sent;
		int phase;
		int n;
		logic dec;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_KEY0;
		cfg_wdata = '0;
		cycles = 0;
		mismatches = 0;
		blocks_checked = 0;
		decrypt_checked = 0;
		settings_used = 1;
		gap_left = 0;
		burst_left = 1;
		hold_left = 0;
		hold_request = 1'b0;
		foreach (key_q[i]) key_q[i] = '0;
		mode_dec = 1'b0;
		chain_lo = TCBC_IV_LOW;
		chain_hi = TCBC_IV_HIGH;

		dir_rows = '{
			'{ROW_BLOCK, CFG_KEY0, TCBC_IV_LOW, TCBC_IV_HIGH, 1'b1, 32'h41EA_3A0A, 32'h94BA_A940},
			'{ROW_BLOCK, CFG_KEY0, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
			'{ROW_BLOCK, CFG_KEY0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
			'{ROW_BLOCK, CFG_KEY0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
			'{ROW_BLOCK, CFG_KEY0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
			'{ROW_REG,   CFG_KEY0, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 32'h0},
			'{ROW_REG,   CFG_KEY1, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 32'h0},
			'{ROW_REG,   CFG_KEY2, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 32'h0},
			'{ROW_REG,   CFG_KEY3, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 32'h0},
			'{ROW_BLOCK, CFG_KEY0, 32'h8000_0000, 32'h0000_0001, 1'b0, 32'h0, 32'h0},
			'{ROW_BLOCK, CFG_KEY0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
			'{ROW_REG,   CFG_SPARE_FIRST, 32'h0000_0000, 32'h0, 1'b0, 32'h0, 32'h0},
			'{ROW_BLOCK, CFG_KEY0, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 32'h0, 32'h0},
			'{ROW_REG,   CFG_KEY0, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 32'h0},
			'{ROW_BLOCK, CFG_KEY0, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
			'{ROW_REG,   CFG_MODE, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 32'h0},
			'{ROW_BLOCK, CFG_KEY0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 32'h0, 32'h0},
			'{ROW_BLOCK, CFG_KEY0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
			'{ROW_BLOCK, CFG_KEY0, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
			'{ROW_REG,   CFG_SPARE_LAST, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 32'h0},
			'{ROW_BLOCK, CFG_KEY0, 32'h1357_9BDF, 32'h2468_ACE0, 1'b0, 32'h0, 32'h0},
			'{ROW_REG,   CFG_MODE, 32'hFFFF_FFFE, 32'h0, 1'b0, 32'h0, 32'h0},
			'{ROW_BLOCK, CFG_KEY0, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
			'{ROW_REG,   CFG_KEY1, 32'h0000_0000, 32'h0, 1'b0, 32'h0, 32'h0},
			'{ROW_BLOCK, CFG_KEY0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0, 32'h0}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG) begin
				wait_idle();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].word_lo);
				settings_used++;
			end else begin
				blocks_to_send.push_back('{dir_rows[i].word_lo, dir_rows[i].word_hi,
					dir_rows[i].known, dir_rows[i].known_lo, dir_rows[i].known_hi});
			end
		end

		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_idle();
			if (phase > 2 && $urandom_range(0, 4) == 0) begin
				// spare index: chain carries on from the previous phase
				write_reg(TCBC_CFG_IW'(CFG_SPARE_FIRST
					+ $urandom_range(0, CFG_SPARE_LAST - CFG_SPARE_FIRST)), $urandom);
			end else begin
				write_reg(CFG_KEY0, pick_word());
				write_reg(CFG_KEY1, pick_word());
				write_reg(CFG_KEY2, pick_word());
				write_reg(CFG_KEY3, pick_word());
				dec = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
				write_reg(CFG_MODE, {31'($urandom_range(0, 32'h7FFF_FFFF)), dec});
			end
			settings_used++;
			if (phase == 2)
				hold_request = 1'b1;
			n = $urandom_range(30, 60);
			repeat (n) blocks_to_send.push_back('{pick_word(), pick_word(), 1'b0, 32'h0, 32'h0});
			sent += n;
			phase++;
		end

		wait_idle();
		$display("%0d blocks checked (%0d decrypted) across %0d key and mode settings",
			blocks_checked, decrypt_checked, settings_used);
		$display("%0d mismatches, long result stall of %0d cycles applied once",
			mismatches, HOLD_CYCLES);
		if (mismatches == 0 && expected_blocks.size() == 0)
			$display("tea_cbc_block_cipher_tb: PASS");
		else
			$display("tea_cbc_block_cipher_tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
